FILE: design/dtdn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtdn_pkg;

   localparam int unsigned YEAR_W     = 14;
   localparam int unsigned MONTH_W    = 4;
   localparam int unsigned DAY_W      = 5;
   localparam int unsigned JDN_W      = 23;
   localparam int unsigned WDAY_W     = 3;
   localparam int unsigned MLEN_W     = 5;
   localparam int unsigned SHIFT_YR_W = 15;
   localparam int unsigned MOFF_W     = 9;
   localparam int unsigned BASE_W     = 14;
   localparam int unsigned CENT_W     = 8;
   localparam int unsigned OFS_W      = 16;

   localparam logic [SHIFT_YR_W-1:0] YEAR_OFFSET   = 15'd4800;
   localparam logic [OFS_W-1:0]      GREG_OFFSET   = 16'd32045;
   localparam logic [OFS_W-1:0]      JUL_OFFSET    = 16'd32083;
   localparam logic [YEAR_W-1:0]     CHANGE_YEAR   = 14'd1752;
   localparam logic [MONTH_W-1:0]    CHANGE_MONTH  = 4'd9;
   localparam logic [DAY_W-1:0]      CHANGE_DAY    = 5'd14;
   localparam logic [MONTH_W-1:0]    MONTH_JAN     = 4'd1;
   localparam logic [MONTH_W-1:0]    MONTH_FEB     = 4'd2;
   localparam logic [MONTH_W-1:0]    MONTH_DEC     = 4'd12;
   localparam logic [12:0]           RECIP_100     = 13'd5243;
   localparam int unsigned           RECIP_SHIFT   = 19;
   localparam logic [8:0]            DAYS_PER_YEAR = 9'd365;
   localparam logic [6:0]            CENTURY       = 7'd100;
   localparam logic [MLEN_W-1:0]     LEAP_FEB_DAYS = 5'd29;

   typedef struct packed {
      logic first;
      logic second;
   } stage_pair_type;

   typedef struct packed {
      logic [JDN_W-1:0]  p365;
      logic [BASE_W-1:0] base;
      logic [CENT_W-1:0] cent;
      logic              greg;
      logic              leap;
      logic [MLEN_W-1:0] mlen;
   } prep_out_type;

   typedef struct packed {
      logic [JDN_W-1:0]  jdn;
      logic [JDN_W-1:0]  jdn_plus1;
      logic              greg;
      logic              leap;
      logic [MLEN_W-1:0] mlen;
   } accum_out_type;

   // days from March 1 to the start of the month, March-based year
   function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [MOFF_W-1:0] r;
      unique case (m)
         4'd3:    r = 9'd0;
         4'd4:    r = 9'd31;
         4'd5:    r = 9'd61;
         4'd6:    r = 9'd92;
         4'd7:    r = 9'd122;
         4'd8:    r = 9'd153;
         4'd9:    r = 9'd184;
         4'd10:   r = 9'd214;
         4'd11:   r = 9'd245;
         4'd12:   r = 9'd275;
         4'd1:    r = 9'd306;
         4'd2:    r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [MLEN_W-1:0] common_month_len(input logic [MONTH_W-1:0] m);
      logic [MLEN_W-1:0] r;
      unique case (m)
         4'd2:                   r = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
         default:                r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: design/dtdn_prep.sv
`timescale 1ns / 1ps
`default_nettype none

module dtdn_prep import dtdn_pkg::*; (
   input  wire logic                 clock,
   input  wire stage_pair_type       stage_en,
   input  wire logic [YEAR_W-1:0]    year,
   input  wire logic [MONTH_W-1:0]   month,
   input  wire logic [DAY_W-1:0]     day,
   output prep_out_type              prep_out
);

   typedef struct packed {
      logic [SHIFT_YR_W-1:0] yy;
      logic [MOFF_W-1:0]     moff;
      logic [DAY_W-1:0]      day;
      logic                  greg;
      logic                  is_feb;
      logic [MLEN_W-1:0]     mlen;
      logic [YEAR_W-1:0]     year;
      logic [26:0]           year_prod;
   } prep_s1_type;

   prep_s1_type  s1_in, s1_ff;
   prep_out_type s2_in, s2_ff;

   logic [MONTH_W-1:0] m_clamp;
   logic               early_month;
   logic [27:0]        yy_prod;
   logic [CENT_W-1:0]  year_cent;
   logic [14:0]        cent_times_100;
   logic               year_div4;
   logic               year_div100;

   // stage 1: clamp month, shift year to March-based epoch, pick calendar
   always_comb begin
      m_clamp = month;
      if (month < MONTH_JAN) begin
         m_clamp = MONTH_JAN;
      end else if (month > MONTH_DEC) begin
         m_clamp = MONTH_DEC;
      end
      early_month = (m_clamp <= MONTH_FEB);

      s1_in.yy     = SHIFT_YR_W'(year) + YEAR_OFFSET - SHIFT_YR_W'(early_month);
      s1_in.moff   = month_offset(m_clamp);
      s1_in.day    = day;
      s1_in.is_feb = (m_clamp == MONTH_FEB);
      s1_in.mlen   = common_month_len(m_clamp);
      s1_in.year   = year;
      s1_in.greg   = (year > CHANGE_YEAR) ||
                     ((year == CHANGE_YEAR) &&
                      ((m_clamp > CHANGE_MONTH) ||
                       ((m_clamp == CHANGE_MONTH) && (day >= CHANGE_DAY))));
      s1_in.year_prod = 27'(year) * 27'(RECIP_100);
   end

   // stage 2: leap rule, year products for the day count
   always_comb begin
      year_cent      = s1_ff.year_prod[RECIP_SHIFT +: CENT_W];
      cent_times_100 = 15'(year_cent) * 15'(CENTURY);
      year_div4      = (s1_ff.year[1:0] == 2'b00);
      year_div100    = (cent_times_100 == 15'(s1_ff.year));
      yy_prod        = 28'(s1_ff.yy) * 28'(RECIP_100);

      s2_in.greg = s1_ff.greg;
      s2_in.leap = s1_ff.greg ? (year_div4 && (!year_div100 || (year_cent[1:0] == 2'b00)))
                              : year_div4;
      s2_in.mlen = (s1_ff.is_feb && s2_in.leap) ? LEAP_FEB_DAYS : s1_ff.mlen;
      s2_in.p365 = JDN_W'(s1_ff.yy) * JDN_W'(DAYS_PER_YEAR);
      s2_in.base = BASE_W'(s1_ff.day) + BASE_W'(s1_ff.moff) + BASE_W'(s1_ff.yy[14:2]);
      s2_in.cent = yy_prod[RECIP_SHIFT +: CENT_W];
   end

   always_ff @(posedge clock) begin
      if (stage_en.first) begin
         s1_ff <= s1_in;
      end
      if (stage_en.second) begin
         s2_ff <= s2_in;
      end
   end

   assign prep_out = s2_ff;

endmodule

`default_nettype wire

FILE: design/dtdn_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module dtdn_accum import dtdn_pkg::*; (
   input  wire logic           clock,
   input  wire stage_pair_type stage_en,
   input  wire prep_out_type   prep_in,
   output accum_out_type       accum_out
);

   typedef struct packed {
      logic [JDN_W-1:0]  pre;
      logic [OFS_W-1:0]  ofs;
      logic [OFS_W-1:0]  ofs_m1;
      logic              greg;
      logic              leap;
      logic [MLEN_W-1:0] mlen;
   } accum_s3_type;

   accum_s3_type  s3_in, s3_ff;
   accum_out_type s4_in, s4_ff;

   // stage 3: sum the year and day terms, select the calendar offset
   always_comb begin
      s3_in.pre  = prep_in.p365 + JDN_W'(prep_in.base);
      s3_in.ofs  = prep_in.greg
                   ? (GREG_OFFSET + OFS_W'(prep_in.cent) - OFS_W'(prep_in.cent >> 2))
                   : JUL_OFFSET;
      s3_in.ofs_m1 = s3_in.ofs - OFS_W'(1);
      s3_in.greg = prep_in.greg;
      s3_in.leap = prep_in.leap;
      s3_in.mlen = prep_in.mlen;
   end

   // stage 4: apply offset; the plus-one copy feeds the weekday
   always_comb begin
      s4_in.jdn       = s3_ff.pre - JDN_W'(s3_ff.ofs);
      s4_in.jdn_plus1 = s3_ff.pre - JDN_W'(s3_ff.ofs_m1);
      s4_in.greg      = s3_ff.greg;
      s4_in.leap      = s3_ff.leap;
      s4_in.mlen      = s3_ff.mlen;
   end

   always_ff @(posedge clock) begin
      if (stage_en.first) begin
         s3_ff <= s3_in;
      end
      if (stage_en.second) begin
         s4_ff <= s4_in;
      end
   end

   assign accum_out = s4_ff;

endmodule

`default_nettype wire

FILE: design/dtdn_wday.sv
`timescale 1ns / 1ps
`default_nettype none

module dtdn_wday import dtdn_pkg::*; (
   input  wire logic               clock,
   input  wire logic               stage_en,
   input  wire accum_out_type      accum_in,
   output logic [JDN_W-1:0]        day_number,
   output logic [WDAY_W-1:0]       weekday_index,
   output logic [MLEN_W-1:0]       month_length,
   output logic                    is_leap,
   output logic                    is_gregorian
);

   localparam int unsigned DIGITS = (JDN_W + 2) / 3;

   logic [3*DIGITS-1:0] padded;
   logic [5:0]          digit_sum;
   logic [3:0]          fold;
   logic [WDAY_W-1:0]   wday_in, wday_ff;
   logic [JDN_W-1:0]    jdn_ff;
   logic [MLEN_W-1:0]   mlen_ff;
   logic                leap_ff;
   logic                greg_ff;

   // 8 == 1 mod 7: add octal digits, fold once, then reduce
   always_comb begin
      padded    = (3*DIGITS)'(accum_in.jdn_plus1);
      digit_sum = '0;
      for (int i = 0; i < DIGITS; i++) begin
         digit_sum = digit_sum + 6'(padded[3*i +: 3]);
      end
      fold = 4'(digit_sum[5:3]) + 4'(digit_sum[2:0]);
      if (fold >= 4'd14) begin
         wday_in = WDAY_W'(fold - 4'd14);
      end else if (fold >= 4'd7) begin
         wday_in = WDAY_W'(fold - 4'd7);
      end else begin
         wday_in = WDAY_W'(fold);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en) begin
         wday_ff <= wday_in;
         jdn_ff  <= accum_in.jdn;
         mlen_ff <= accum_in.mlen;
         leap_ff <= accum_in.leap;
         greg_ff <= accum_in.greg;
      end
   end

   assign day_number    = jdn_ff;
   assign weekday_index = wday_ff;
   assign month_length  = mlen_ff;
   assign is_leap       = leap_ff;
   assign is_gregorian  = greg_ff;

endmodule

`default_nettype wire

FILE: design/date_to_day_number_weekday.sv
// Five register stages from req to rsp. Throughput: one date per cycle
// unless rsp_ready stalls the output; each stage holds one item and advances
// whenever the stage after it is empty or advancing, so bubbles close up.
// Reset: synchronous, active high; clears the stage valid bits only.
`timescale 1ns / 1ps
`default_nettype none

module date_to_day_number_weekday import dtdn_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [YEAR_W-1:0]   req_year,
   input  wire logic [MONTH_W-1:0]  req_month,
   input  wire logic [DAY_W-1:0]    req_day,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [JDN_W-1:0]         rsp_day_number,
   output logic [WDAY_W-1:0]        rsp_weekday_index,
   output logic [MLEN_W-1:0]        rsp_month_length,
   output logic                     rsp_is_leap,
   output logic                     rsp_is_gregorian
);

   localparam int unsigned STAGES = 5;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] stage_en;
   stage_pair_type    prep_en, accum_en;
   prep_out_type      prep_out;
   accum_out_type     accum_out;

   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
      valid_in = {valid_ff[STAGES-2:0], req_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_ready = stage_en[0];
   assign rsp_valid = valid_ff[STAGES-1];

   assign prep_en  = '{first: stage_en[0], second: stage_en[1]};
   assign accum_en = '{first: stage_en[2], second: stage_en[3]};

   dtdn_prep u_prep (
      .clock    (clock),
      .stage_en (prep_en),
      .year     (req_year),
      .month    (req_month),
      .day      (req_day),
      .prep_out (prep_out)
   );

   dtdn_accum u_accum (
      .clock     (clock),
      .stage_en  (accum_en),
      .prep_in   (prep_out),
      .accum_out (accum_out)
   );

   dtdn_wday u_wday (
      .clock         (clock),
      .stage_en      (stage_en[4]),
      .accum_in      (accum_out),
      .day_number    (rsp_day_number),
      .weekday_index (rsp_weekday_index),
      .month_length  (rsp_month_length),
      .is_leap       (rsp_is_leap),
      .is_gregorian  (rsp_is_gregorian)
   );

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output stage empty");

   a_advance_to_output: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && stage_en[4]) |=> rsp_valid)
      else $error("item lost between last two stages");

   a_weekday_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_weekday_index != 3'd7))
      else $error("weekday out of range");

   a_leap_feb: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_month_length == LEAP_FEB_DAYS)) |-> rsp_is_leap)
      else $error("29-day month without leap year");

endmodule

`default_nettype wire

FILE: dv/jdn_date_checker.sv
`timescale 1ns / 1ps

module jdn_date_checker import dtdn_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [YEAR_W-1:0]  req_year,
   input  logic [MONTH_W-1:0] req_month,
   input  logic [DAY_W-1:0]   req_day,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [JDN_W-1:0]   rsp_day_number,
   input  logic [WDAY_W-1:0]  rsp_weekday_index,
   input  logic [MLEN_W-1:0]  rsp_month_length,
   input  logic               rsp_is_leap,
   input  logic               rsp_is_gregorian,
   output int                 mismatch_count,
   output int                 pending_days,
   output int                 checked_days
);

   typedef struct packed {
      logic [JDN_W-1:0]  day_number;
      logic [WDAY_W-1:0] weekday;
      logic [MLEN_W-1:0] month_len;
      logic              leap;
      logic              greg;
   } day_info_type;

   day_info_type expected_days_q[$];
   int           errors = 0;
   int           checked = 0;

   function automatic day_info_type civil_date_to_jdn(input logic [YEAR_W-1:0]  yr,
                                                      input logic [MONTH_W-1:0] mon_in,
                                                      input logic [DAY_W-1:0]   dom);
      logic [MONTH_W-1:0] mon;
      int unsigned        y;
      int unsigned        m;
      int unsigned        a;
      int unsigned        sy;
      int unsigned        sm;
      int unsigned        jdn;
      bit                 greg;
      bit                 leap;
      day_info_type       r;
      mon = mon_in;
      if (mon < MONTH_JAN) mon = MONTH_JAN;
      if (mon > MONTH_DEC) mon = MONTH_DEC;
      y = 32'(yr);
      m = 32'(mon);
      if (yr != CHANGE_YEAR) begin
         greg = (yr > CHANGE_YEAR);
      end else begin
         greg = (mon > CHANGE_MONTH) || ((mon == CHANGE_MONTH) && (dom >= CHANGE_DAY));
      end
      if (greg) begin
         leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      end else begin
         leap = (y % 4 == 0);
      end
      // count from a March-based year so the leap day lands at year end
      a   = (14 - m) / 12;
      sy  = y + 4800 - a;
      sm  = m + 12 * a - 3;
      jdn = 32'(dom) + (153 * sm + 2) / 5 + 365 * sy + sy / 4;
      if (greg) begin
         jdn = jdn + sy / 400 - sy / 100 - 32045;
      end else begin
         jdn = jdn - 32083;
      end
      r.day_number = jdn[JDN_W-1:0];
      r.weekday    = WDAY_W'((jdn + 1) % 7);
      case (mon)
         MONTH_FEB:              r.month_len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: r.month_len = 5'd30;
         default:                r.month_len = 5'd31;
      endcase
      r.leap = leap;
      r.greg = greg;
      return r;
   endfunction

   task automatic flag_field(input string name, input logic [31:0] want, input logic [31:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
   endtask

   always @(posedge clock) begin
      day_info_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            expected_days_q.push_back(civil_date_to_jdn(req_year, req_month, req_day));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_days_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual day_number %0d",
                        $time, rsp_day_number);
               errors++;
            end else begin
               want = expected_days_q.pop_front();
               checked++;
               if (rsp_day_number !== want.day_number)
                  flag_field("day_number", 32'(want.day_number), 32'(rsp_day_number));
               if (rsp_weekday_index !== want.weekday)
                  flag_field("weekday_index", 32'(want.weekday), 32'(rsp_weekday_index));
               if (rsp_month_length !== want.month_len)
                  flag_field("month_length", 32'(want.month_len), 32'(rsp_month_length));
               if (rsp_is_leap !== want.leap)
                  flag_field("is_leap", 32'(want.leap), 32'(rsp_is_leap));
               if (rsp_is_gregorian !== want.greg)
                  flag_field("is_gregorian", 32'(want.greg), 32'(rsp_is_gregorian));
            end
         end
      end
      mismatch_count <= errors;
      pending_days   <= expected_days_q.size();
      checked_days   <= checked;
   end

endmodule

FILE: dv/date_to_day_number_weekday_tb.sv
`timescale 1ns / 1ps

module date_to_day_number_weekday_tb import dtdn_pkg::*;;

   localparam int RANDOM_DATES = 1600;
   localparam int QUIET_START  = 600;
   localparam int QUIET_END    = 800;
   localparam int DRAIN_START  = 1300;
   localparam int STALL_AT     = 400;
   localparam int STALL_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 200000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [YEAR_W-1:0]  req_year;
   logic [MONTH_W-1:0] req_month;
   logic [DAY_W-1:0]   req_day;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [JDN_W-1:0]   rsp_day_number;
   logic [WDAY_W-1:0]  rsp_weekday_index;
   logic [MLEN_W-1:0]  rsp_month_length;
   logic               rsp_is_leap;
   logic               rsp_is_gregorian;

   int mismatch_count;
   int pending_days;
   int checked_days;
   int dates_sent    = 0;
   int directed_sent = 0;
   int cycle_count   = 0;
   bit idle_enable   = 1;
   bit stall_done    = 0;

   date_to_day_number_weekday i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day           (req_day),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_day_number    (rsp_day_number),
      .rsp_weekday_index (rsp_weekday_index),
      .rsp_month_length  (rsp_month_length),
      .rsp_is_leap       (rsp_is_leap),
      .rsp_is_gregorian  (rsp_is_gregorian)
   );

   jdn_date_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day           (req_day),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_day_number    (rsp_day_number),
      .rsp_weekday_index (rsp_weekday_index),
      .rsp_month_length  (rsp_month_length),
      .rsp_is_leap       (rsp_is_leap),
      .rsp_is_gregorian  (rsp_is_gregorian),
      .mismatch_count    (mismatch_count),
      .pending_days      (pending_days),
      .checked_days      (checked_days)
   );

   initial begin
      clock     = 1'b0;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_year  = '0;
      req_month = '0;
      req_day   = '0;
      rsp_ready = 1'b0;
   end

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
   end

   // result side: random stalls, one long hold-off to back up the pipeline
   initial begin
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (!stall_done && dates_sent >= STALL_AT) begin
            rsp_ready <= 1'b0;
            hold = 0;
            while (hold < STALL_CYCLES) begin
               @(negedge clock);
               hold++;
            end
            stall_done = 1'b1;
            rsp_ready <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // call at a falling edge; returns at the falling edge after the transfer
   task automatic send_date(input logic [YEAR_W-1:0]  y,
                            input logic [MONTH_W-1:0] m,
                            input logic [DAY_W-1:0]   d);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_year  <= y;
      req_month <= m;
      req_day   <= d;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      dates_sent++;
      @(negedge clock);
   endtask

   initial begin
      logic [YEAR_W-1:0]  y;
      logic [MONTH_W-1:0] m;
      logic [DAY_W-1:0]   d;
      int                 pick;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_date(14'd1, 4'd1, 5'd1);
      send_date(14'd9999, 4'd12, 5'd31);
      send_date(14'd0, 4'd1, 5'd1);
      send_date(14'd16383, 4'd15, 5'd31);
      send_date(14'd1752, 4'd9, 5'd2);
      send_date(14'd1752, 4'd9, 5'd3);
      send_date(14'd1752, 4'd9, 5'd13);
      send_date(14'd1752, 4'd9, 5'd14);
      send_date(14'd1752, 4'd8, 5'd31);
      send_date(14'd1752, 4'd10, 5'd1);
      send_date(14'd1752, 4'd2, 5'd29);
      send_date(14'd1752, 4'd12, 5'd31);
      send_date(14'd1700, 4'd2, 5'd29);
      send_date(14'd1800, 4'd2, 5'd1);
      send_date(14'd1900, 4'd2, 5'd28);
      send_date(14'd2000, 4'd2, 5'd29);
      send_date(14'd2024, 4'd2, 5'd31);
      send_date(14'd1999, 4'd0, 5'd15);
      send_date(14'd1999, 4'd13, 5'd15);
      send_date(14'd2001, 4'd4, 5'd0);
      send_date(14'd2001, 4'd6, 5'd31);
      send_date(14'd4, 4'd11, 5'd30);
      send_date(14'd10922, 4'd10, 5'd21);
      send_date(14'd5461, 4'd5, 5'd10);
      directed_sent = dates_sent;

      for (int i = 0; i < RANDOM_DATES; i++) begin
         if (i == QUIET_START || i == DRAIN_START) idle_enable <= 1'b0;
         if (i == QUIET_END) idle_enable <= 1'b1;
         pick = int'($urandom_range(0, 9));
         if (pick == 0) begin
            y = YEAR_W'($urandom_range(0, (1 << YEAR_W) - 1));
            m = MONTH_W'($urandom_range(0, (1 << MONTH_W) - 1));
            d = DAY_W'($urandom_range(0, (1 << DAY_W) - 1));
         end else if (pick <= 2) begin
            // dwell on the changeover
            y = ($urandom_range(0, 1) == 0) ? 14'd1752 : 14'($urandom_range(1740, 1765));
            m = MONTH_W'($urandom_range(8, 10));
            d = DAY_W'($urandom_range(0, 31));
         end else begin
            y = YEAR_W'($urandom_range(1, 9999));
            m = MONTH_W'($urandom_range(1, 12));
            d = DAY_W'($urandom_range(1, 31));
         end
         send_date(y, m, d);
      end
      req_valid <= 1'b0;

      while (pending_days != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      @(negedge clock);
      $display("sent %0d dates (%0d directed); %0d results compared field by field",
               dates_sent, directed_sent, checked_days);
      $display("covered the 1752 changeover, both leap rules, clamped months, "
               , "zero and all-ones fields, and a long result stall");
      if (mismatch_count == 0 && pending_days == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

FILE: date_to_day_number_weekday.f
design/dtdn_pkg.sv
design/dtdn_prep.sv
design/dtdn_accum.sv
design/dtdn_wday.sv
design/date_to_day_number_weekday.sv
dv/jdn_date_checker.sv
dv/date_to_day_number_weekday_tb.sv
